// ===== hw/rtl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and codes of the ticket list engine: operation and status
// codes, fixed field widths and the command group that drives the cell row.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int OP_BITS     = 2;
    localparam int POS_BITS    = 6;
    localparam int STATUS_BITS = 3;

    typedef logic [OP_BITS-1:0]     op_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    localparam op_t OP_APPEND = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_READ   = 2'd2;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_FULL      = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_RANGE     = 3'd4;

    typedef struct packed {
        logic append;
        logic remove;
    } tle_cmd_t;

endpackage

// ===== hw/rtl/tle_if.sv =====
// ----------------------------------------------------------------------------
// tle_req_if / tle_rsp_if
// Valid/ready channels of the ticket list engine: one request channel and
// one response channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface tle_req_if
    import tle_pkg::*;
#(
    parameter int ID_BITS = 16
) ();
    logic                valid;
    logic                ready;
    logic [OP_BITS-1:0]  operation;
    logic [ID_BITS-1:0]  thread_id;
    logic [POS_BITS-1:0] position;

    modport source (output valid, output operation, output thread_id,
                    output position, input ready);
    modport sink   (input valid, input operation, input thread_id,
                    input position, output ready);
endinterface

interface tle_rsp_if
    import tle_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int COUNT_BITS = 7
) ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     result_id;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (output valid, output status, output result_id,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input result_id,
                    input entry_count, output ready);
endinterface

// ===== hw/rtl/ticket_list_engine.sv =====
// ----------------------------------------------------------------------------
// ticket_list_engine
// Ordered list of thread ids kept in a row of slot cells: append at the
// tail, remove the first matching id and close the gap, read by position.
// ----------------------------------------------------------------------------
// Path: a request is held in the request register, then passes through
//   the cell row into the response register.
// Throughput: one request per cycle while responses are taken; the row's
//   match and read chains are combinational and settle before the response register.
// Reset: count and handshake state clear at once; slot contents stay
//   undefined until written and no clearing pass is needed.
module ticket_list_engine
    import tle_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int ID_BITS  = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    tle_req_if.sink      req,
    tle_rsp_if.source    rsp
);

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS   = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

    logic                  req_valid_reg;
    logic                  req_valid_next;
    op_t                   op_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [POS_BITS-1:0]   pos_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               status_reg;
    status_t               status_next;
    logic [ID_BITS-1:0]    result_reg;
    logic [ID_BITS-1:0]    result_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_out_reg;

    logic                  fire_exec;
    logic                  req_fire;
    tle_cmd_t              cmd;

    logic [ID_BITS-1:0]    slots    [CAPACITY];
    logic                  hit_chain[CAPACITY+1];
    logic [ID_BITS-1:0]    rd_chain [CAPACITY+1];

    assign fire_exec = req_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || fire_exec;
    assign req_fire  = req.valid && req.ready;

    assign cmd.append = fire_exec && (op_reg == OP_APPEND) && (count_reg != FULL_COUNT);
    assign cmd.remove = fire_exec && (op_reg == OP_REMOVE);

    assign hit_chain[0] = 1'b0;
    assign rd_chain[0]  = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ID_BITS-1:0] right_slot;
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_slot = '0;
        end
        else
        begin : g_mid
            assign right_slot = slots[i+1];
        end

        tle_cell #(
            .ID_BITS    (ID_BITS),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .id         (id_reg),
            .pos        (pos_reg),
            .right_slot (right_slot),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .rd_in      (rd_chain[i]),
            .rd_out     (rd_chain[i+1]),
            .slot       (slots[i])
        );
    end

    always_comb
    begin
        status_next = ST_OK;
        result_next = '0;
        count_next  = count_reg;
        unique case (op_reg)
            OP_APPEND:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            OP_REMOVE:
            begin
                if (hit_chain[CAPACITY])
                begin
                    result_next = id_reg;
                    count_next  = count_reg - COUNT_BITS'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_READ:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (CMP_BITS'(pos_reg) >= CMP_BITS'(count_reg))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    result_next = rd_chain[CAPACITY];
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_fire)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire_exec)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire_exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire_exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.operation;
            id_reg  <= req.thread_id;
            pos_reg <= req.position;
        end
        if (fire_exec)
        begin
            status_reg    <= status_next;
            result_reg    <= result_next;
            count_out_reg <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.result_id   = result_reg;
    assign rsp.entry_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire_exec |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.remove && hit_chain[CAPACITY]) |=>
            (count_reg == $past(count_reg) - COUNT_BITS'(1)))
        else $error("matched remove did not shrink the list");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (result_reg == '0))
        else $error("nonzero id on a failed request");

    a_resp_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire_exec |=> (count_out_reg == count_reg))
        else $error("reported count differs from list count");

endmodule

// ===== hw/rtl/tle_cell.sv =====
// ----------------------------------------------------------------------------
// tle_cell
// One list slot. Appends when its index equals the count, shifts in its
// right neighbor once the first match lies at or left of it, and drives the
// read chain when its index equals the requested position.
// ----------------------------------------------------------------------------
module tle_cell
    import tle_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int COUNT_BITS = 7,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  tle_cmd_t              cmd,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [ID_BITS-1:0]    id,
    input  logic [POS_BITS-1:0]   pos,
    input  logic [ID_BITS-1:0]    right_slot,
    input  logic                  hit_in,
    output logic                  hit_out,
    input  logic [ID_BITS-1:0]    rd_in,
    output logic [ID_BITS-1:0]    rd_out,
    output logic [ID_BITS-1:0]    slot
);

    localparam int CMP_BITS = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;
    localparam logic [COUNT_BITS-1:0] MY_INDEX = COUNT_BITS'(INDEX);
    localparam logic [CMP_BITS-1:0]   MY_POS   = CMP_BITS'(INDEX);

    logic [ID_BITS-1:0] slot_reg;
    logic [ID_BITS-1:0] slot_next;
    logic               active;
    logic               match;
    logic               shift;

    assign active  = MY_INDEX < count;
    assign match   = cmd.remove && active && (slot_reg == id);
    assign hit_out = hit_in || match;
    assign shift   = cmd.remove && hit_out;
    assign rd_out  = (CMP_BITS'(pos) == MY_POS) ? (rd_in | slot_reg) : rd_in;
    assign slot    = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.append && (count == MY_INDEX))
        begin
            slot_next = id;
        end
        else if (shift)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== sim/ticket_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ticket_list_checker
// Watches the request and response channels of the ticket list engine. It
// keeps its own copy of the id list and, for each accepted request, works out
// the expected status, id and entry count. It checks each accepted response
// against the oldest expected one.
// ----------------------------------------------------------------------------
module ticket_list_checker
    import tle_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int ID_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    tle_req_if   req,
    tle_rsp_if   rsp,
    output int   failures,
    output int   pending
);

    localparam int COUNT_BITS = 7;

    typedef logic [ID_BITS-1:0] ticket_id_t;

    typedef struct packed {
        status_t               status;
        ticket_id_t            result_id;
        logic [COUNT_BITS-1:0] entry_count;
    } ticket_rsp_t;

    ticket_id_t  ticket_list[$];
    ticket_rsp_t expected_rsp[$];

    function automatic ticket_rsp_t apply_ticket_op(op_t op, ticket_id_t tid,
                                                    logic [POS_BITS-1:0] pos);
        ticket_rsp_t r;
        int          i;
        r.status    = ST_OK;
        r.result_id = '0;
        case (op)
            OP_APPEND:
                if (ticket_list.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                    ticket_list.push_back(tid);
            OP_REMOVE:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < ticket_list.size(); i++)
                begin
                    if (ticket_list[i] == tid)
                    begin
                        ticket_list.delete(i);
                        r.status    = ST_OK;
                        r.result_id = tid;
                        break;
                    end
                end
            end
            OP_READ:
                if (ticket_list.size() == 0)
                    r.status = ST_EMPTY;
                else if (int'(pos) >= ticket_list.size())
                    r.status = ST_RANGE;
                else
                    r.result_id = ticket_list[pos];
            default:
                r.status = ST_RANGE;
        endcase
        r.entry_count = COUNT_BITS'(ticket_list.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ticket_rsp_t want;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            ticket_list.delete();
            expected_rsp.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_rsp.push_back(apply_ticket_op(req.operation, req.thread_id,
                                                       req.position));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, actual status %0d id %h count %0d",
                             $time, rsp.status, rsp.result_id, rsp.entry_count);
                    errs++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        errs++;
                    end
                    if (rsp.result_id !== want.result_id)
                    begin
                        $display("%0t: result_id mismatch: expected %h actual %h",
                                 $time, want.result_id, rsp.result_id);
                        errs++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                                 $time, want.entry_count, rsp.entry_count);
                        errs++;
                    end
                end
            end
            failures <= failures + errs;
            pending  <= expected_rsp.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ticket list engine with a short directed sequence (empty list,
// extreme ids, duplicates, reads past the end, the reserved operation) and
// then with random fill, drain and mixed stretches under varying idling on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench
    import tle_pkg::*;
();

    localparam int  CAPACITY       = 64;
    localparam int  ID_BITS        = 16;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  ITEMS_PER_RUN  = 600;
    localparam op_t OP_RESERVED    = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   pending;
    int   req_idle_pct;
    int   rsp_idle_pct;
    int   hold_off_left = 0;
    int   quiet_cycles  = 0;

    logic [ID_BITS-1:0] wide_ids[8] = '{16'hFFFF, 16'h8000, 16'hAAAA, 16'h5555,
                                        16'h7FFF, 16'hC3C3, 16'h1234, 16'hFEDC};

    tle_req_if #(.ID_BITS(ID_BITS))                  req_ch ();
    tle_rsp_if #(.ID_BITS(ID_BITS), .COUNT_BITS(7)) rsp_ch ();

    ticket_list_engine #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ticket_list_checker #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) list_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .failures (failures),
        .pending  (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    task automatic send_request(op_t op, logic [ID_BITS-1:0] tid,
                                logic [POS_BITS-1:0] pos);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.thread_id <= tid;
        req_ch.position  <= pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [ID_BITS-1:0] pick_ticket_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return ID_BITS'($urandom_range(0, 15));
        if (r < 85)
            return wide_ids[3'($urandom_range(0, 7))];
        return ID_BITS'($urandom);
    endfunction

    task automatic send_random(int append_pct, int remove_pct);
        int  r;
        op_t op;
        r = $urandom_range(0, 99);
        if (r < append_pct)
            op = OP_APPEND;
        else if (r < append_pct + remove_pct)
            op = OP_REMOVE;
        else if (r < 98)
            op = OP_READ;
        else
            op = OP_RESERVED;
        send_request(op, pick_ticket_id(), POS_BITS'($urandom_range(0, 63)));
    endtask

    task automatic run_random(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            case ((n / 75) % 3)
                0:       send_random(88, 4);
                1:       send_random(10, 70);
                default: send_random(35, 35);
            endcase
        end
    endtask

    initial
    begin
        int n;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_APPEND;
        req_ch.thread_id = '0;
        req_ch.position  = '0;
        req_idle_pct     = 34;
        rsp_idle_pct     = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_READ,     16'h0000, 6'd0);
        send_request(OP_REMOVE,   16'h0000, 6'd0);
        send_request(OP_RESERVED, 16'hFFFF, 6'd63);
        send_request(OP_APPEND,   16'h0000, 6'd63);
        send_request(OP_APPEND,   16'hFFFF, 6'd0);
        send_request(OP_APPEND,   16'hA5A5, 6'd0);
        send_request(OP_APPEND,   16'hFFFF, 6'd0);
        send_request(OP_APPEND,   16'h5A5A, 6'd0);
        send_request(OP_READ,     16'hFFFF, 6'd0);
        send_request(OP_READ,     16'h0000, 6'd4);
        send_request(OP_READ,     16'h0000, 6'd5);
        send_request(OP_READ,     16'h0000, 6'd63);
        send_request(OP_REMOVE,   16'hFFFF, 6'd0);
        send_request(OP_READ,     16'h0000, 6'd1);
        send_request(OP_REMOVE,   16'h1234, 6'd0);
        send_request(OP_REMOVE,   16'h5A5A, 6'd0);
        send_request(OP_REMOVE,   16'h0000, 6'd0);
        send_request(OP_RESERVED, 16'h0000, 6'd0);
        send_request(OP_READ,     16'h0000, 6'd0);

        run_random(ITEMS_PER_RUN);
        drain_responses();

        req_idle_pct = 50;
        rsp_idle_pct = 34;
        run_random(ITEMS_PER_RUN);
        drain_responses();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_off_left = 40;
        for (n = 0; n < 24; n++)
            send_random(50, 25);
        drain_responses();
        run_random(ITEMS_PER_RUN);

        drain_responses();
        repeat (10) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== ticket_list_engine.f =====
hw/rtl/tle_pkg.sv
hw/rtl/tle_if.sv
hw/rtl/tle_cell.sv
hw/rtl/ticket_list_engine.sv
sim/ticket_list_checker.sv
sim/testbench.sv
